FILE: rtl/core/date_validate_weekday_bcd_unit_macros.svh
// Assertion macros for the date check and BCD unit.
// Used by the RTL files that check their own control logic; no dependencies.
`ifndef DATE_VALIDATE_WEEKDAY_BCD_UNIT_MACROS_SVH
`define DATE_VALIDATE_WEEKDAY_BCD_UNIT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge out of reset.
`define DVWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define DVWB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define DVWB_ASSERT(lbl, prop, msg)
`define DVWB_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/core/dvwb_pkg.sv
// Shared types, constants and table functions for the date check and BCD unit.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package dvwb_pkg;

  localparam logic [7:0] SEC_MAX   = 8'd59;
  localparam logic [7:0] MIN_MAX   = 8'd59;
  localparam logic [7:0] HOUR_MAX  = 8'd23;
  localparam logic [7:0] DAY_MAX   = 8'd31;
  localparam logic [7:0] MONTH_MAX = 8'd12;
  localparam logic [7:0] YEAR_MAX  = 8'd99;
  localparam logic [3:0] FEBRUARY  = 4'd2;

  // 365 days is one week-step a year, so whole years add the year count itself.
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam logic [8:0]  YEAR_STEP     = 9'(DAYS_PER_YEAR % 7);

  // 2000-01-01 was a Saturday: day one of the count lands on weekday six, and
  // the count starts from the first of the month, hence six minus one.
  localparam logic [8:0] EPOCH_OFFSET = 9'd5;

  localparam logic [8:0] FOLD_LIMIT = 9'd7;

  typedef struct packed {
    logic load;
    logic calc;
    logic fold;
    logic emit;
  } dvwb_cmd_t;

  typedef struct packed {
    logic fold_done;
    logic slot_free;
  } dvwb_status_t;

  // Length of a month in a common year; zero for codes that are no month.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the given month.
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] days;
    unique case (month)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Packed BCD of a value from 0 to 99.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int t = 1; t <= 9; t++) begin
      if (v >= 7'(10 * t)) begin
        tens = 4'(t);
      end
    end
    ones = v - 7'(10 * tens);
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dvwb_ctrl.sv
// Sequencer of the date check and BCD unit: input handshake and step commands.
// Depends on dvwb_pkg and the assertion macro header.
`default_nettype none

`include "date_validate_weekday_bcd_unit_macros.svh"

module dvwb_ctrl
  import dvwb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire dvwb_status_t status_i,
  output dvwb_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_FOLD = 4'b0100,
    ST_HOLD = 4'b1000
  } dvwb_state_e;

  dvwb_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_FOLD;
      end
      ST_FOLD: begin
        if (!status_i.fold_done) begin
          cmd_o.fold = 1'b1;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // The weekday is settled; wait until the previous result is taken.
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DVWB_ASSERT(a_emit_needs_slot, cmd_o.emit |-> status_i.slot_free, "output overwritten")
  `DVWB_ASSERT(a_accept_calc, in_valid_i && !in_stall_o |=> state_q == ST_CALC, "item not started")
  `DVWB_ASSERT_NEVER(a_fold_and_emit, cmd_o.fold && cmd_o.emit, "emit during fold")
  `DVWB_ASSERT(a_emit_then_ready, cmd_o.emit |=> !in_stall_o, "not ready after a result")

endmodule

`default_nettype wire

FILE: rtl/core/dvwb_datapath.sv
// Datapath of the date check and BCD unit: input capture, range check, weekday
// sum with mod-7 folding, BCD packing and the output register. Depends on dvwb_pkg.
`default_nettype none

module dvwb_datapath
  import dvwb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire dvwb_cmd_t    cmd_i,
  output dvwb_status_t      status_o,
  input  wire logic [7:0]   sec_bin_i,
  input  wire logic [7:0]   min_bin_i,
  input  wire logic [7:0]   hour_bin_i,
  input  wire logic [7:0]   day_bin_i,
  input  wire logic [7:0]   month_bin_i,
  input  wire logic [7:0]   year_bin_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [6:0]        sec_bcd_o,
  output logic [6:0]        min_bcd_o,
  output logic [5:0]        hour_bcd_o,
  output logic [2:0]        weekday_o,
  output logic [5:0]        day_bcd_o,
  output logic [4:0]        month_bcd_o,
  output logic [7:0]        year_bcd_o,
  output logic              date_error_o
);

  logic [7:0] sec_q, min_q, hour_q, day_q, month_q, year_q;
  logic       ok_q, ok_d;
  logic [8:0] sum_q, sum_d;
  logic       out_valid_q, out_valid_d;

  logic       range_ok;
  logic       leap_year;
  logic [4:0] day_limit;
  logic [8:0] year_ext;
  logic [8:0] leap_days;
  logic [8:0] leap_adj;
  logic [2:0] weekday_c;
  logic [7:0] sec_bcd_c, min_bcd_c, hour_bcd_c, day_bcd_c, month_bcd_c, year_bcd_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sec_q   <= sec_bin_i;
      min_q   <= min_bin_i;
      hour_q  <= hour_bin_i;
      day_q   <= day_bin_i;
      month_q <= month_bin_i;
      year_q  <= year_bin_i;
    end
  end

  always_comb begin
    range_ok = (sec_q <= SEC_MAX) && (min_q <= MIN_MAX) && (hour_q <= HOUR_MAX) &&
               (day_q != 8'd0) && (day_q <= DAY_MAX) && (month_q != 8'd0) &&
               (month_q <= MONTH_MAX) && (year_q <= YEAR_MAX);
    leap_year = (year_q[1:0] == 2'b00);
    day_limit = month_len(month_q[3:0]);
    if ((month_q[3:0] == FEBRUARY) && leap_year) begin
      day_limit = 5'd29;
    end
    ok_d = range_ok && (day_q[4:0] <= day_limit);

    year_ext  = {1'b0, year_q};
    // Leap days of the years before this one, 2000 counting as a leap year.
    leap_days = (year_ext + 9'd3) >> 2;
    leap_adj  = 9'((month_q[3:0] > FEBRUARY) && leap_year);
    sum_d     = {1'b0, day_q} + days_before(month_q[3:0]) + leap_adj +
                9'(year_ext * YEAR_STEP) + leap_days + EPOCH_OFFSET;
  end

  // Folding eight into one keeps the value's residue modulo seven.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      ok_q  <= ok_d;
      sum_q <= sum_d;
    end else if (cmd_i.fold) begin
      sum_q <= {3'b000, sum_q[8:3]} + {6'd0, sum_q[2:0]};
    end
  end

  assign weekday_c = (sum_q[2:0] == 3'd7) ? 3'd0 : sum_q[2:0];

  assign sec_bcd_c   = to_bcd(sec_q[6:0]);
  assign min_bcd_c   = to_bcd(min_q[6:0]);
  assign hour_bcd_c  = to_bcd(hour_q[6:0]);
  assign day_bcd_c   = to_bcd(day_q[6:0]);
  assign month_bcd_c = to_bcd(month_q[6:0]);
  assign year_bcd_c  = to_bcd(year_q[6:0]);

  assign status_o.fold_done = (sum_q <= FOLD_LIMIT);
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (ok_q) begin
        sec_bcd_o    <= sec_bcd_c[6:0];
        min_bcd_o    <= min_bcd_c[6:0];
        hour_bcd_o   <= hour_bcd_c[5:0];
        weekday_o    <= weekday_c;
        day_bcd_o    <= day_bcd_c[5:0];
        month_bcd_o  <= month_bcd_c[4:0];
        year_bcd_o   <= year_bcd_c;
        date_error_o <= 1'b0;
      end else begin
        sec_bcd_o    <= '0;
        min_bcd_o    <= '0;
        hour_bcd_o   <= '0;
        weekday_o    <= '0;
        day_bcd_o    <= '0;
        month_bcd_o  <= '0;
        year_bcd_o   <= '0;
        date_error_o <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/date_validate_weekday_bcd_unit.sv
// Date check, day of week and BCD packing for years 2000 to 2099.
// From input accept to result valid the item is captured, then checked and summed,
// then folded mod 7 up to three times, and then written to the output register.
// The input stalls until the previous item has reached the output register.
// Asynchronous active-low reset clears the sequencer and the output valid.
`default_nettype none

module date_validate_weekday_bcd_unit
  import dvwb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] sec_bin_i,
  input  wire logic [7:0] min_bin_i,
  input  wire logic [7:0] hour_bin_i,
  input  wire logic [7:0] day_bin_i,
  input  wire logic [7:0] month_bin_i,
  input  wire logic [7:0] year_bin_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      sec_bcd_o,
  output logic [6:0]      min_bcd_o,
  output logic [5:0]      hour_bcd_o,
  output logic [2:0]      weekday_o,
  output logic [5:0]      day_bcd_o,
  output logic [4:0]      month_bcd_o,
  output logic [7:0]      year_bcd_o,
  output logic            date_error_o
);

  dvwb_cmd_t    cmd;
  dvwb_status_t status;

  dvwb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dvwb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sec_bin_i    (sec_bin_i),
    .min_bin_i    (min_bin_i),
    .hour_bin_i   (hour_bin_i),
    .day_bin_i    (day_bin_i),
    .month_bin_i  (month_bin_i),
    .year_bin_i   (year_bin_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sec_bcd_o    (sec_bcd_o),
    .min_bcd_o    (min_bcd_o),
    .hour_bcd_o   (hour_bcd_o),
    .weekday_o    (weekday_o),
    .day_bcd_o    (day_bcd_o),
    .month_bcd_o  (month_bcd_o),
    .year_bcd_o   (year_bcd_o),
    .date_error_o (date_error_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/date_checker.sv
`timescale 1ns / 100ps
// Result checker for the date check and BCD unit: watches both channels, predicts each
// result from the accepted input item and compares it with the one the unit returns.
// Uses the field limits of dvwb_pkg; instantiated by tb_top beside the unit.
module date_checker
  import dvwb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  sec_bin_i,
  input  logic [7:0]  min_bin_i,
  input  logic [7:0]  hour_bin_i,
  input  logic [7:0]  day_bin_i,
  input  logic [7:0]  month_bin_i,
  input  logic [7:0]  year_bin_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [6:0]  sec_bcd_o,
  input  logic [6:0]  min_bcd_o,
  input  logic [5:0]  hour_bcd_o,
  input  logic [2:0]  weekday_o,
  input  logic [5:0]  day_bcd_o,
  input  logic [4:0]  month_bcd_o,
  input  logic [7:0]  year_bcd_o,
  input  logic        date_error_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o,
  output int unsigned reject_count_o
);

  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hour;
    logic [2:0] weekday;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
    logic       err;
  } rtc_result_t;

  localparam int unsigned REPORT_LIMIT = 10;

  rtc_result_t expected_q[$];
  int unsigned fail_count   = 0;
  int unsigned result_count = 0;
  int unsigned reject_count = 0;

  function automatic int unsigned days_in_month(input int unsigned month,
                                                input int unsigned year);
    if (month == FEBRUARY) begin
      return (year % 4 == 0) ? 29 : 28;
    end
    case (month)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic logic [7:0] bcd_of(input int unsigned v);
    return 8'(v + 6 * (v / 10));
  endfunction

  // The day count starts at zero on 2000-01-01, which was a Saturday.
  function automatic rtc_result_t predict_rtc_result(input logic [7:0] sec, mn, hr,
                                                     input logic [7:0] dy, mo, yr);
    rtc_result_t res;
    int unsigned day_count;
    int unsigned y;
    res     = '0;
    res.err = 1'b1;
    y       = yr;
    if (sec > SEC_MAX || mn > MIN_MAX || hr > HOUR_MAX || dy == 0 || mo == 0 ||
        mo > MONTH_MAX || yr > YEAR_MAX) begin
      return res;
    end
    if (dy > days_in_month(mo, y)) begin
      return res;
    end
    day_count = dy + 365 * y + (y + 3) / 4 - 1;
    for (int m = 1; m < mo; m++) begin
      day_count += days_in_month(m, y);
    end
    res.sec     = 7'(bcd_of(sec));
    res.min     = 7'(bcd_of(mn));
    res.hour    = 6'(bcd_of(hr));
    res.weekday = 3'((day_count + 6) % 7);
    res.day     = 6'(bcd_of(dy));
    res.month   = 5'(bcd_of(mo));
    res.year    = bcd_of(yr);
    res.err     = 1'b0;
    return res;
  endfunction

  function automatic string format_result(input rtc_result_t r);
    return $sformatf("err %0b sec %02h min %02h hour %02h wday %0d day %02h mon %02h year %02h",
                     r.err, r.sec, r.min, r.hour, r.weekday, r.day, r.month, r.year);
  endfunction

  always @(posedge clk_i) begin : watch_channels
    rtc_result_t got;
    rtc_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {sec_bcd_o, min_bcd_o, hour_bcd_o, weekday_o, day_bcd_o, month_bcd_o,
               year_bcd_o, date_error_o};
        result_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: result with nothing outstanding: %s", $time, format_result(got));
          end
        end else begin
          want = expected_q.pop_front();
          if (want.err) begin
            reject_count++;
          end
          if (got.err !== want.err || got.sec !== want.sec || got.min !== want.min ||
              got.hour !== want.hour || got.weekday !== want.weekday ||
              got.day !== want.day || got.month !== want.month || got.year !== want.year) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", format_result(want));
              $display("  actual   %s", format_result(got));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict_rtc_result(sec_bin_i, min_bin_i, hour_bin_i,
                                                day_bin_i, month_bin_i, year_bin_i));
      end
    end
    fail_count_o   <= fail_count;
    pending_o      <= expected_q.size();
    result_count_o <= result_count;
    reject_count_o <= reject_count;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the testbench for date_validate_weekday_bcd_unit: clock, reset, date stimulus
// with random idling on both channels, and the verdict. Depends on date_checker.
module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned IDLE_PHASE   = 150;
  localparam int unsigned SETTLE_WAIT  = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] sec_bin_i   = '0;
  logic [7:0] min_bin_i   = '0;
  logic [7:0] hour_bin_i  = '0;
  logic [7:0] day_bin_i   = '0;
  logic [7:0] month_bin_i = '0;
  logic [7:0] year_bin_i  = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [6:0] sec_bcd_o;
  logic [6:0] min_bcd_o;
  logic [5:0] hour_bcd_o;
  logic [2:0] weekday_o;
  logic [5:0] day_bcd_o;
  logic [4:0] month_bcd_o;
  logic [7:0] year_bcd_o;
  logic       date_error_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned reject_count;
  int unsigned sent_count  = 0;
  int unsigned stall_left  = 0;
  bit          idle_on     = 1'b1;

  date_validate_weekday_bcd_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sec_bin_i    (sec_bin_i),
    .min_bin_i    (min_bin_i),
    .hour_bin_i   (hour_bin_i),
    .day_bin_i    (day_bin_i),
    .month_bin_i  (month_bin_i),
    .year_bin_i   (year_bin_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sec_bcd_o    (sec_bcd_o),
    .min_bcd_o    (min_bcd_o),
    .hour_bcd_o   (hour_bcd_o),
    .weekday_o    (weekday_o),
    .day_bcd_o    (day_bcd_o),
    .month_bcd_o  (month_bcd_o),
    .year_bcd_o   (year_bcd_o),
    .date_error_o (date_error_o)
  );

  date_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sec_bin_i      (sec_bin_i),
    .min_bin_i      (min_bin_i),
    .hour_bin_i     (hour_bin_i),
    .day_bin_i      (day_bin_i),
    .month_bin_i    (month_bin_i),
    .year_bin_i     (year_bin_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sec_bcd_o      (sec_bcd_o),
    .min_bcd_o      (min_bcd_o),
    .hour_bcd_o     (hour_bcd_o),
    .weekday_o      (weekday_o),
    .day_bcd_o      (day_bcd_o),
    .month_bcd_o    (month_bcd_o),
    .year_bcd_o     (year_bcd_o),
    .date_error_o   (date_error_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count),
    .result_count_o (result_count),
    .reject_count_o (reject_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side back-pressure: random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [7:0] month_length(input logic [7:0] month, input logic [7:0] year);
    case (month)
      8'd2:                     return (year % 4 == 0) ? 8'd29 : 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11: return 8'd30;
      default:                  return 8'd31;
    endcase
  endfunction

  // Presents one item, holds it until taken, then sometimes leaves a gap.
  task automatic send_date(input logic [7:0] s, mi, h, d, mo, y);
    sec_bin_i   <= s;
    min_bin_i   <= mi;
    hour_bin_i  <= h;
    day_bin_i   <= d;
    month_bin_i <= mo;
    year_bin_i  <= y;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sent_count++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // The outstanding count is a registered copy, hence the first wait before reading it.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Mostly well-formed dates, some with a single field pushed out of range,
  // and a share of fully random bytes.
  task automatic send_random_date();
    logic [7:0] s, mi, h, d, mo, y;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    s    = $urandom_range(0, 59);
    mi   = $urandom_range(0, 59);
    h    = $urandom_range(0, 23);
    mo   = $urandom_range(1, 12);
    y    = $urandom_range(0, 99);
    if (kind < 5) begin
      mo = 8'd2;
      d  = 8'd29;
    end else if ($urandom_range(0, 3) == 0) begin
      d = month_length(mo, y);
    end else begin
      d = $urandom_range(1, month_length(mo, y));
    end
    if (kind >= 70 && kind < 88) begin
      case ($urandom_range(0, 5))
        0: s  = $urandom_range(60, 255);
        1: mi = $urandom_range(60, 255);
        2: h  = $urandom_range(24, 255);
        3: begin
          case ($urandom_range(0, 2))
            0:       d = 8'd0;
            1:       d = month_length(mo, y) + 8'd1;
            default: d = $urandom_range(32, 255);
          endcase
        end
        4: mo = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(13, 255));
        default: y = $urandom_range(100, 255);
      endcase
    end else if (kind >= 88) begin
      s  = $urandom_range(0, 255);
      mi = $urandom_range(0, 255);
      h  = $urandom_range(0, 255);
      d  = $urandom_range(0, 255);
      mo = $urandom_range(0, 255);
      y  = $urandom_range(0, 255);
    end
    send_date(s, mi, h, d, mo, y);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Range edges, month lengths, leap days and every kind of bad field.
    send_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0);
    send_date(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99);
    send_date(8'd30, 8'd30, 8'd12, 8'd29, 8'd2, 8'd0);
    send_date(8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 8'd96);
    send_date(8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 8'd1);
    send_date(8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 8'd99);
    send_date(8'd0, 8'd0, 8'd0, 8'd30, 8'd2, 8'd4);
    send_date(8'd0, 8'd0, 8'd0, 8'd28, 8'd2, 8'd3);
    send_date(8'd0, 8'd0, 8'd0, 8'd31, 8'd4, 8'd10);
    send_date(8'd0, 8'd0, 8'd0, 8'd30, 8'd4, 8'd10);
    send_date(8'd60, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0);
    send_date(8'd0, 8'd60, 8'd0, 8'd1, 8'd1, 8'd0);
    send_date(8'd0, 8'd0, 8'd24, 8'd1, 8'd1, 8'd0);
    send_date(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0);
    send_date(8'd0, 8'd0, 8'd0, 8'd32, 8'd1, 8'd0);
    send_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0);
    send_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd13, 8'd0);
    send_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd100);
    send_date(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd96);
    send_date(8'd0, 8'd0, 8'd0, 8'd31, 8'd12, 8'd96);
    send_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd97);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on <= (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / IDLE_PHASE) % 2 == 0);
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      send_random_date();
    end
    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk_i);

    $display("Sent %0d date items; %0d results checked, %0d of them rejected dates.",
             sent_count, result_count, reject_count);
    $display("Failures counted: %0d.", fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending_count);
    $display("status: fail");
    $finish;
  end

endmodule
